/* src/decs_pkg.sv */
// ----------------------------------------------------------------------------
// decs_pkg: shared types and constants
// Sizes, kind codes, character codes, sequencer states and a case-fold function for the entry sorter.
// ----------------------------------------------------------------------------
package decs_pkg;
   localparam int MAX_ENTRIES = 64;
   localparam int NAME_BYTES  = 63;
   localparam int EW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int BW = $clog2(NAME_BYTES + 1);
   localparam int AW = $clog2(MAX_ENTRIES * NAME_BYTES);

   localparam logic [1:0] KIND_FILE = 2'd0;
   localparam logic [1:0] KIND_DIR  = 2'd1;
   localparam logic [1:0] KIND_EXEC = 2'd2;

   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_L     = 8'h6c;
   localparam logic [7:0] CH_F     = 8'h66;

   typedef enum logic [3:0] {
      ST_LOAD, ST_INIT, ST_OUTER, ST_RDPREV, ST_META, ST_CMPRD, ST_CMP,
      ST_SHIFT, ST_PLACE, ST_ERD, ST_EMIT
   } state_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5a) fold = c + 8'd32;
      else fold = c;
   endfunction
endpackage

/* src/dir_entry_classify_sort.sv */
// ----------------------------------------------------------------------------
// dir_entry_classify_sort
// Loads names byte by byte, classifies entries, insertion-sorts, emits.
// ----------------------------------------------------------------------------
// Sequence: one name byte per cycle while loading (when req_valid); the closing
// byte of the set starts the sort: setup, an outer step per entry, and per
// insertion step the fetch states, a compare per byte (at most L+1, L = shorter
// name length) and a shift or place, up to N*(N-1)/2 steps; then results emit.
// Throughput: one listing at a time; req_ready is low during sort and emit.
// Reset: synchronous, clears counters and state; stores are not cleared.
module dir_entry_classify_sort import decs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_name_byte,
   input  logic        req_name_end,
   input  logic [30:0] req_entry_size,
   input  logic        req_set_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_source_position,
   output logic        rsp_is_folder,
   output logic [1:0]  rsp_kind_code,
   output logic [30:0] rsp_size_out,
   output logic        rsp_last_out
);
   logic [7:0]  name_mem [MAX_ENTRIES*NAME_BYTES];
   logic [BW-1:0] len_mem [MAX_ENTRIES];
   logic        fold_mem [MAX_ENTRIES];
   logic [1:0]  kind_mem [MAX_ENTRIES];
   logic [30:0] size_mem [MAX_ENTRIES];
   logic [EW-1:0] ord_mem [MAX_ENTRIES];

   state_type state_ff, state_in;
   logic [CW-1:0] ent_ff, ent_in, i_ff, i_in, j_ff, j_in;
   logic [BW-1:0] bc_ff, bc_in, k_ff, k_in;
   logic seen_dot_ff, seen_dot_in;
   logic [7:0] b1_ff, b2_ff, b3_ff, b4_ff;
   logic [EW-1:0] cur_ff, cur_in, prv_ff;
   logic [BW-1:0] lc_ff, lp_ff;
   logic fc_ff, fp_ff;
   logic [7:0] ca_ff, cb_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [5:0] o_pos_ff;
   logic o_fold_ff, o_last_ff, o_last_in;
   logic [1:0] o_kind_ff;
   logic [30:0] o_size_ff;

   logic accept, accepting, store_byte, goes_ahead, lt_done;
   logic [CW-1:0] jm1;
   logic [AW-1:0] wr_addr, rd_a, rd_b;
   logic [BW-1:0] minl, cls_len;
   logic cls_dir;
   logic [1:0] cls_kind;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_LOAD);
   assign accepting = ent_ff < CW'(MAX_ENTRIES);
   assign store_byte = accept && accepting && (bc_ff < BW'(NAME_BYTES));
   assign wr_addr = AW'(ent_ff[EW-1:0] * NAME_BYTES) + AW'(bc_ff);
   assign jm1 = j_ff - CW'(1);
   assign rd_a = AW'(cur_ff * NAME_BYTES) + AW'(k_ff);
   assign rd_b = AW'(prv_ff * NAME_BYTES) + AW'(k_ff);
   assign minl = (lc_ff < lp_ff) ? lc_ff : lp_ff;

   // classification from the byte that closes the name
   always_comb begin
      logic [BW-1:0] len;
      logic [7:0] l1, l2, l3, l4;
      len = store_byte ? bc_ff + BW'(1) : bc_ff;
      if (store_byte) begin
         l1 = req_name_byte; l2 = b1_ff; l3 = b2_ff; l4 = b3_ff;
      end else begin
         l1 = b1_ff; l2 = b2_ff; l3 = b3_ff; l4 = b4_ff;
      end
      cls_kind = KIND_FILE;
      if (len != '0 && l1 == CH_SLASH) begin
         cls_dir = 1'b1;
         len = len - BW'(1);
         l1 = l2; l2 = l3; l3 = l4;
      end else begin
         cls_dir = !(seen_dot_ff || (store_byte && req_name_byte == CH_DOT));
      end
      if (cls_dir) cls_kind = KIND_DIR;
      else if (len >= BW'(4) && l4 == CH_DOT && fold(l3) == CH_E &&
               fold(l2) == CH_L && fold(l1) == CH_F) cls_kind = KIND_EXEC;
      cls_len = len;
   end

   always_comb begin
      if (fc_ff != fp_ff) goes_ahead = fc_ff;
      else if (k_ff >= minl) goes_ahead = lc_ff < lp_ff;
      else goes_ahead = ca_ff < cb_ff;
      lt_done = (fc_ff != fp_ff) || (k_ff >= minl);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:  if (accept && req_name_end && req_set_end) state_in = ST_INIT;
         ST_INIT:  state_in = ST_OUTER;
         ST_OUTER: if (i_ff >= ent_ff) state_in = (ent_ff == '0) ? ST_LOAD : ST_ERD;
                   else state_in = ST_RDPREV;
         ST_RDPREV: state_in = (j_ff == '0) ? ST_PLACE : ST_META;
         ST_META:  state_in = ST_CMPRD;
         ST_CMPRD: state_in = ST_CMP;
         ST_CMP: begin
            if (lt_done || ca_ff != cb_ff)
               state_in = goes_ahead ? ST_SHIFT : ST_PLACE;
            else state_in = ST_CMPRD;
         end
         ST_SHIFT: state_in = ST_RDPREV;
         ST_PLACE: state_in = ST_OUTER;
         ST_ERD:   state_in = ST_EMIT;
         ST_EMIT:  if (rsp_valid_ff && rsp_ready)
                      state_in = o_last_ff ? ST_LOAD : ST_ERD;
         default:  state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      ent_in = ent_ff; bc_in = bc_ff; seen_dot_in = seen_dot_ff;
      i_in = i_ff; j_in = j_ff; k_in = k_ff; cur_in = cur_ff;
      rsp_valid_in = rsp_valid_ff; o_last_in = o_last_ff;
      case (state_ff)
         ST_LOAD: if (accept) begin
            if (store_byte) begin
               bc_in = bc_ff + BW'(1);
               if (req_name_byte == CH_DOT) seen_dot_in = 1'b1;
            end
            if (req_name_end) begin
               bc_in = '0; seen_dot_in = 1'b0;
               if (accepting) ent_in = ent_ff + CW'(1);
            end
         end
         ST_INIT: i_in = CW'(1);
         ST_OUTER: begin j_in = i_ff; cur_in = EW'(i_ff); i_in = '0; end
         ST_RDPREV: k_in = '0;
         ST_CMP: k_in = k_ff + BW'(1);
         ST_SHIFT: j_in = jm1;
         ST_PLACE: i_in = j_ff;
         ST_ERD: o_last_in = (i_ff + CW'(1) == ent_ff);
         // first emit cycle loads the result fields, valid follows
         ST_EMIT: if (!rsp_valid_ff) begin
            rsp_valid_in = 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_in = 1'b0; i_in = i_ff + CW'(1);
            if (o_last_ff) ent_in = '0;
         end
         default: ;
      endcase
      if (state_ff == ST_OUTER && i_ff >= ent_ff) i_in = '0;
      if (state_ff == ST_OUTER && i_ff < ent_ff) i_in = i_ff;
      if (state_ff == ST_PLACE) i_in = i_ff + CW'(1);
      if (state_ff == ST_OUTER && ent_ff == '0 && i_ff >= ent_ff) ent_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD; ent_ff <= '0; bc_ff <= '0; seen_dot_ff <= 1'b0;
         i_ff <= '0; j_ff <= '0; k_ff <= '0; rsp_valid_ff <= 1'b0;
         o_last_ff <= 1'b0; cur_ff <= '0;
      end else begin
         state_ff <= state_in; ent_ff <= ent_in; bc_ff <= bc_in;
         seen_dot_ff <= seen_dot_in; i_ff <= i_in; j_ff <= j_in; k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in; o_last_ff <= o_last_in; cur_ff <= cur_in;
      end
   end

   // datapath and stores
   always_ff @(posedge clock) begin
      if (store_byte) begin
         name_mem[wr_addr] <= req_name_byte;
         b4_ff <= b3_ff; b3_ff <= b2_ff; b2_ff <= b1_ff; b1_ff <= req_name_byte;
      end
      if (accept && req_name_end && accepting) begin
         len_mem[ent_ff[EW-1:0]]  <= cls_len;
         fold_mem[ent_ff[EW-1:0]] <= cls_dir;
         kind_mem[ent_ff[EW-1:0]] <= cls_kind;
         size_mem[ent_ff[EW-1:0]] <= cls_dir ? 31'd0 : req_entry_size;
      end
      case (state_ff)
         ST_INIT: ord_mem[EW'(0)] <= '0;
         ST_OUTER: if (i_ff < ent_ff) begin
            ord_mem[i_ff[EW-1:0]] <= EW'(i_ff);
            lc_ff <= len_mem[i_ff[EW-1:0]];
            fc_ff <= fold_mem[i_ff[EW-1:0]];
         end
         ST_RDPREV: if (j_ff != '0) prv_ff <= ord_mem[jm1[EW-1:0]];
         ST_META: begin lp_ff <= len_mem[prv_ff]; fp_ff <= fold_mem[prv_ff]; end
         ST_CMPRD: begin ca_ff <= fold(name_mem[rd_a]); cb_ff <= fold(name_mem[rd_b]); end
         ST_SHIFT: ord_mem[j_ff[EW-1:0]] <= prv_ff;
         ST_PLACE: ord_mem[j_ff[EW-1:0]] <= cur_ff;
         ST_ERD: o_pos_ff <= 6'(ord_mem[i_ff[EW-1:0]]);
         default: ;
      endcase
   end

   logic [EW-1:0] opos;
   assign opos = EW'(o_pos_ff);
   always_ff @(posedge clock) begin
      o_fold_ff <= fold_mem[opos];
      o_kind_ff <= kind_mem[opos];
      o_size_ff <= size_mem[opos];
   end

   assign rsp_valid = rsp_valid_ff && (state_ff == ST_EMIT);
   assign rsp_source_position = o_pos_ff;
   assign rsp_is_folder = o_fold_ff;
   assign rsp_kind_code = o_kind_ff;
   assign rsp_size_out = o_size_ff;
   assign rsp_last_out = o_last_ff;
endmodule
